// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the countdown timer checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cdt assertion failed");

// Next-cycle implication, held off during reset.
`define CDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cdt assertion failed");

`endif

// ===== rtl/cdt_pkg.sv =====
// ---------------------------------------------------------------------------
// cdt_pkg
// Shared types and constants of the countdown timer.
// ---------------------------------------------------------------------------
`default_nettype none

package cdt_pkg;

	localparam int unsigned MAX_DURATION_S_DEF = 359999;

	localparam int CMD_W   = 3;
	localparam int DELTA_W = 20;
	localparam int CFG_W   = 19;
	localparam int MS_W    = 29;
	localparam int HRS_W   = 7;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int PROG_W  = 17;
	localparam int TOT_S_W = 20;

	localparam logic [MS_W-1:0] W29_MAX      = '1;
	localparam logic [MS_W-1:0] DUR_RESET_MS = 29'd300000;
	localparam int unsigned     MS_PER_S     = 1000;

	// Reciprocals for the constant divisions (exact over their input ranges).
	localparam logic [30:0] RECIP_1000 = 31'd1099511628; // ceil(2^40/1000)
	localparam int          SHIFT_1000 = 40;
	localparam logic [20:0] RECIP_3600 = 21'd1193047;    // ceil(2^32/3600)
	localparam int          SHIFT_3600 = 32;
	localparam logic [12:0] RECIP_60   = 13'd4370;       // ceil(2^18/60)
	localparam int          SHIFT_60   = 18;

	// Quotient bits of the progress divider.
	localparam int PROG_QW = 17;

	typedef enum logic [1:0] {
		RS_IDLE     = 2'd0,
		RS_RUNNING  = 2'd1,
		RS_PAUSED   = 2'd2,
		RS_FINISHED = 2'd3
	} run_state_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 3'd0,
		CMD_START  = 3'd1,
		CMD_PAUSE  = 3'd2,
		CMD_RESUME = 3'd3,
		CMD_RESET  = 3'd4,
		CMD_ADD    = 3'd5,
		CMD_ACK    = 3'd6
	} cmd_code_t;

	typedef enum logic [3:0] {
		C_IDLE,
		C_APPLY,
		C_REM,
		C_SEC,
		C_HRS,
		C_HREM,
		C_MIN,
		C_SECS,
		C_PUSH
	} ctrl_state_t;

	typedef struct packed {
		logic take;
		logic apply;
		logic rem;
		logic sec;
		logic hrs;
		logic hrem;
		logic mins;
		logic secs;
		logic load_out;
	} ctl_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/cdt_ifs.sv =====
// ---------------------------------------------------------------------------
// cdt_ifs
// Command and result channels of the countdown timer.
// ---------------------------------------------------------------------------
`default_nettype none

interface cdt_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [cdt_pkg::CMD_W-1:0]           command;
	logic signed [cdt_pkg::DELTA_W-1:0]  delta_seconds;

	modport source (output valid, command, delta_seconds, input ready);
	modport sink (input valid, command, delta_seconds, output ready);
endinterface

interface cdt_res_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   timer_state;
	logic [cdt_pkg::MS_W-1:0]     remaining_ms;
	logic [cdt_pkg::HRS_W-1:0]    show_hours;
	logic [cdt_pkg::MIN_W-1:0]    show_minutes;
	logic [cdt_pkg::SEC_W-1:0]    show_seconds;
	logic [cdt_pkg::PROG_W-1:0]   progress_fraction;
	logic                         finished_pulse;

	modport source (output valid, timer_state, remaining_ms, show_hours, show_minutes,
		show_seconds, progress_fraction, finished_pulse, input ready);
	modport sink (input valid, timer_state, remaining_ms, show_hours, show_minutes,
		show_seconds, progress_fraction, finished_pulse, output ready);
endinterface

`default_nettype wire

// ===== rtl/cdt_prog_div.sv =====
// ---------------------------------------------------------------------------
// cdt_prog_div
// Bit-serial restoring divider: floor(elapsed * 2^16 / divisor), elapsed <= divisor.
// ---------------------------------------------------------------------------
`default_nettype none

module cdt_prog_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [cdt_pkg::MS_W-1:0]      elapsed,
	input  wire logic [cdt_pkg::MS_W-1:0]      divisor,
	output logic                               busy,
	output logic [cdt_pkg::PROG_QW-1:0]        quot
);

	localparam int CNT_W = $clog2(cdt_pkg::PROG_QW + 1);

	logic [cdt_pkg::MS_W:0]          rem_q;
	logic [cdt_pkg::PROG_QW-1:0]     quot_q;
	logic [CNT_W-1:0]                cnt_q;
	logic                            first_q;
	logic [cdt_pkg::MS_W:0]          trial;
	logic [cdt_pkg::MS_W:0]          dvs;
	logic                            ge;

	// First step tests elapsed itself (integer quotient bit), later ones shift.
	assign trial = first_q ? rem_q : {rem_q[cdt_pkg::MS_W-1:0], 1'b0};
	assign dvs   = {1'b0, divisor};
	assign ge    = (trial >= dvs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			first_q <= 1'b0;
		end else if (start) begin
			cnt_q   <= CNT_W'(cdt_pkg::PROG_QW);
			first_q <= 1'b1;
		end else if (busy) begin
			cnt_q   <= cnt_q - 1'b1;
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, elapsed};
			quot_q <= '0;
		end else if (busy) begin
			rem_q  <= ge ? (trial - dvs) : trial;
			quot_q <= {quot_q[cdt_pkg::PROG_QW-2:0], ge};
		end
	end

	assign busy = (cnt_q != '0);
	assign quot = quot_q;

endmodule

`default_nettype wire

// ===== rtl/cdt_datapath.sv =====
// ---------------------------------------------------------------------------
// cdt_datapath
// Timer state, config, command execution, time split, progress divider and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module cdt_datapath #(
	parameter int unsigned MAX_DURATION_S = cdt_pkg::MAX_DURATION_S_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [cdt_pkg::CFG_W-1:0]          cfg_wr_data,
	input  wire logic [cdt_pkg::CMD_W-1:0]          in_command,
	input  wire logic signed [cdt_pkg::DELTA_W-1:0] in_delta,
	input  wire cdt_pkg::ctl_t                      ctl,
	output cdt_pkg::sts_t                           sts,
	input  wire logic                               out_ready,
	output logic                                    out_valid,
	output logic [1:0]                              out_state,
	output logic [cdt_pkg::MS_W-1:0]                out_rem,
	output logic [cdt_pkg::HRS_W-1:0]               out_hours,
	output logic [cdt_pkg::MIN_W-1:0]               out_minutes,
	output logic [cdt_pkg::SEC_W-1:0]               out_seconds,
	output logic [cdt_pkg::PROG_W-1:0]              out_progress,
	output logic                                    out_pulse
);

	localparam longint unsigned CAP_FULL = longint'(MAX_DURATION_S) * cdt_pkg::MS_PER_S;
	localparam logic [cdt_pkg::MS_W-1:0] CAP_MS =
		(CAP_FULL > longint'(cdt_pkg::W29_MAX)) ? cdt_pkg::W29_MAX
		: cdt_pkg::MS_W'(CAP_FULL);
	localparam logic [31:0] MAX_S = 32'(MAX_DURATION_S);
	localparam int MS_W = cdt_pkg::MS_W;

	// architectural state
	cdt_pkg::run_state_t            state_q;
	logic [MS_W-1:0]                cons_q;
	logic [MS_W-1:0]                wd_q;
	logic                           pulse_q;

	// latched command
	cdt_pkg::cmd_code_t             cmd_q;
	logic signed [cdt_pkg::DELTA_W-1:0] delta_q;

	// result computation
	logic [MS_W-1:0]                rem_q;
	logic [MS_W-1:0]                elapsed_q;
	logic [MS_W:0]                  xsec_q;
	logic [cdt_pkg::TOT_S_W-1:0]    tot_s_q;
	logic [8:0]                     hours_q;
	logic [11:0]                    rem_h_q;
	logic [cdt_pkg::MIN_W-1:0]      mins_q;
	logic [cdt_pkg::SEC_W-1:0]      secs_q;

	// command execution
	cdt_pkg::run_state_t            nxt_state;
	logic [MS_W-1:0]                nxt_cons;
	logic [MS_W-1:0]                nxt_wd;
	logic                           nxt_pulse;
	logic [MS_W-1:0]                cons_inc;
	logic [MS_W:0]                  floor_ms;
	logic signed [MS_W+1:0]         delta_ms;
	logic signed [MS_W+1:0]         want_s;
	logic signed [MS_W+1:0]         floor_s;
	logic signed [MS_W+1:0]         nd_s;
	logic [MS_W-1:0]                add_wd;

	// config
	logic [31:0]                    s_wide;
	logic [31:0]                    s_cl;
	logic [31:0]                    ms_wide;
	logic [MS_W-1:0]                cfg_ms;

	// arithmetic products, divider outputs and result valid
	logic [60:0]                    prod_sec;
	logic [40:0]                    prod_hrs;
	logic [24:0]                    prod_min;
	logic [cdt_pkg::PROG_QW-1:0]    div_quot;
	logic                           div_busy;
	logic                           out_valid_q;

	assign s_wide  = {{(32-cdt_pkg::CFG_W){1'b0}}, cfg_wr_data};
	assign s_cl    = (s_wide == '0) ? 32'd1 : ((s_wide > MAX_S) ? MAX_S : s_wide);
	assign ms_wide = s_cl * 32'(cdt_pkg::MS_PER_S);
	assign cfg_ms  = (ms_wide > {3'b0, CAP_MS}) ? CAP_MS : ms_wide[MS_W-1:0];

	assign cons_inc = (cons_q != cdt_pkg::W29_MAX) ? (cons_q + 1'b1) : cons_q;
	assign floor_ms = {1'b0, cons_q} + (MS_W+1)'(cdt_pkg::MS_PER_S);
	assign delta_ms = (MS_W+2)'(delta_q) * (MS_W+2)'(signed'(cdt_pkg::MS_PER_S));
	assign want_s   = $signed({2'b0, wd_q}) + delta_ms;
	assign floor_s  = $signed({1'b0, floor_ms});
	assign nd_s     = (want_s > floor_s) ? want_s : floor_s;
	assign add_wd   = (nd_s > $signed({2'b0, CAP_MS})) ? CAP_MS : nd_s[MS_W-1:0];

	always_comb begin
		nxt_state = state_q;
		nxt_cons  = cons_q;
		nxt_wd    = wd_q;
		nxt_pulse = 1'b0;
		case (cmd_q)
			cdt_pkg::CMD_TICK: begin
				if (state_q == cdt_pkg::RS_RUNNING) begin
					nxt_cons = cons_inc;
					if (wd_q <= cons_inc) begin
						nxt_cons  = wd_q;
						nxt_state = cdt_pkg::RS_FINISHED;
						nxt_pulse = 1'b1;
					end
				end
			end
			cdt_pkg::CMD_START: begin
				nxt_cons  = '0;
				nxt_state = cdt_pkg::RS_RUNNING;
			end
			cdt_pkg::CMD_PAUSE: begin
				if (state_q == cdt_pkg::RS_RUNNING)
					nxt_state = cdt_pkg::RS_PAUSED;
			end
			cdt_pkg::CMD_RESUME: begin
				if (state_q == cdt_pkg::RS_PAUSED)
					nxt_state = cdt_pkg::RS_RUNNING;
			end
			cdt_pkg::CMD_RESET: begin
				nxt_cons  = '0;
				nxt_state = cdt_pkg::RS_IDLE;
			end
			cdt_pkg::CMD_ADD: begin
				nxt_wd = add_wd;
				if (state_q == cdt_pkg::RS_FINISHED && add_wd > cons_q)
					nxt_state = cdt_pkg::RS_RUNNING;
			end
			cdt_pkg::CMD_ACK: begin
				if (state_q == cdt_pkg::RS_FINISHED) begin
					nxt_cons  = '0;
					nxt_state = cdt_pkg::RS_IDLE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdt_pkg::RS_IDLE;
			cons_q  <= '0;
			wd_q    <= cdt_pkg::DUR_RESET_MS;
			pulse_q <= 1'b0;
		end else if (ctl.apply) begin
			state_q <= nxt_state;
			cons_q  <= nxt_cons;
			wd_q    <= nxt_wd;
			pulse_q <= nxt_pulse;
		end else if (cfg_wr_en && cfg_ms != wd_q) begin
			wd_q <= cfg_ms;
			if (state_q == cdt_pkg::RS_IDLE || state_q == cdt_pkg::RS_FINISHED) begin
				state_q <= cdt_pkg::RS_IDLE;
				cons_q  <= '0;
			end
		end
	end

	assign prod_sec = 61'(xsec_q) * 61'(cdt_pkg::RECIP_1000);
	assign prod_hrs = 41'(tot_s_q) * 41'(cdt_pkg::RECIP_3600);
	assign prod_min = 25'(rem_h_q) * 25'(cdt_pkg::RECIP_60);

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			cmd_q   <= cdt_pkg::cmd_code_t'(in_command);
			delta_q <= in_delta;
		end
		if (ctl.rem) begin
			rem_q     <= (wd_q > cons_q) ? (wd_q - cons_q) : '0;
			elapsed_q <= (wd_q > cons_q) ? cons_q : wd_q;
			xsec_q    <= (wd_q > cons_q) ? ({1'b0, wd_q - cons_q} + (MS_W+1)'(999)) : '0;
		end
		if (ctl.sec)
			tot_s_q <= prod_sec[cdt_pkg::SHIFT_1000 +: cdt_pkg::TOT_S_W];
		if (ctl.hrs)
			hours_q <= prod_hrs[cdt_pkg::SHIFT_3600 +: 9];
		if (ctl.hrem)
			rem_h_q <= 12'(tot_s_q - 20'(hours_q) * 20'd3600);
		if (ctl.mins)
			mins_q <= prod_min[cdt_pkg::SHIFT_60 +: cdt_pkg::MIN_W];
		if (ctl.secs)
			secs_q <= cdt_pkg::SEC_W'(rem_h_q - 12'(mins_q) * 12'd60);
	end

	cdt_prog_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctl.sec),
		.elapsed (elapsed_q),
		.divisor (wd_q),
		.busy    (div_busy),
		.quot    (div_quot)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_state    <= state_q;
			out_rem      <= rem_q;
			out_hours    <= (hours_q > 9'd127) ? 7'd127 : hours_q[cdt_pkg::HRS_W-1:0];
			out_minutes  <= mins_q;
			out_seconds  <= secs_q;
			out_progress <= (wd_q == '0) ? '0 : div_quot;
			out_pulse    <= pulse_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.div_done = ~div_busy;
	assign sts.out_free = ~out_valid_q | out_ready;

endmodule

`default_nettype wire

// ===== rtl/cdt_ctrl.sv =====
// ---------------------------------------------------------------------------
// cdt_ctrl
// Sequencer: takes one command, steps the datapath, hands off the result.
// ---------------------------------------------------------------------------
`default_nettype none

module cdt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire cdt_pkg::sts_t sts,
	output cdt_pkg::ctl_t      ctl
);

	cdt_pkg::ctrl_state_t state_q;
	cdt_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= cdt_pkg::C_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			cdt_pkg::C_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.take = 1'b1;
					state_d  = cdt_pkg::C_APPLY;
				end
			end
			cdt_pkg::C_APPLY: begin
				ctl.apply = 1'b1;
				state_d   = cdt_pkg::C_REM;
			end
			cdt_pkg::C_REM: begin
				ctl.rem = 1'b1;
				state_d = cdt_pkg::C_SEC;
			end
			cdt_pkg::C_SEC: begin
				ctl.sec = 1'b1;
				state_d = cdt_pkg::C_HRS;
			end
			cdt_pkg::C_HRS: begin
				ctl.hrs = 1'b1;
				state_d = cdt_pkg::C_HREM;
			end
			cdt_pkg::C_HREM: begin
				ctl.hrem = 1'b1;
				state_d  = cdt_pkg::C_MIN;
			end
			cdt_pkg::C_MIN: begin
				ctl.mins = 1'b1;
				state_d  = cdt_pkg::C_SECS;
			end
			cdt_pkg::C_SECS: begin
				ctl.secs = 1'b1;
				state_d  = cdt_pkg::C_PUSH;
			end
			cdt_pkg::C_PUSH: begin
				// wait for the divider and a free result register
				if (sts.div_done && sts.out_free) begin
					ctl.load_out = 1'b1;
					state_d      = cdt_pkg::C_IDLE;
				end
			end
			default: state_d = cdt_pkg::C_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/countdown_timer_pause_extend_core.sv =====
// ---------------------------------------------------------------------------
// countdown_timer_pause_extend_core
// Millisecond countdown timer with pause, resume and extend.
//
// Usage:
//   cmd  - command channel (valid/ready). Each transfer is one command:
//          1 ms tick, start, pause, resume, reset, add seconds, acknowledge.
//   res  - result channel (valid/ready). Exactly one transfer per command,
//          showing state, remaining ms, rounded-up h:m:s, progress (16 frac
//          bits) and a finish flag on the tick that ends the countdown.
//   cfg_wr_en / cfg_wr_data - duration in seconds; write only with no
//          command in flight.
// Sequence: after a command is taken, the controller applies it, registers the
//   remaining time, starts the divider and splits h:m:s during its 17 steps,
//   then loads the result register once the divider is done and the register
//   is free; the next command is accepted only after that load.
// Stall: the next command is accepted while a result still waits in the
//   result register; a second result waits until that one is taken.
// Reset: arst_n puts the timer idle with a 300 s duration; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module countdown_timer_pause_extend_core #(
	parameter int unsigned MAX_DURATION_S = cdt_pkg::MAX_DURATION_S_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [cdt_pkg::CFG_W-1:0]  cfg_wr_data,
	cdt_cmd_if.sink                         cmd,
	cdt_res_if.source                       res
);

	// controller <-> datapath
	cdt_pkg::ctl_t ctl;
	cdt_pkg::sts_t sts;

	cdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// Datapath holds the timer state and the result register; the duration
	// cap follows from MAX_DURATION_S.
	cdt_datapath #(
		.MAX_DURATION_S (MAX_DURATION_S)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_command   (cmd.command),
		.in_delta     (cmd.delta_seconds),
		.ctl          (ctl),
		.sts          (sts),
		.out_ready    (res.ready),
		.out_valid    (res.valid),
		.out_state    (res.timer_state),
		.out_rem      (res.remaining_ms),
		.out_hours    (res.show_hours),
		.out_minutes  (res.show_minutes),
		.out_seconds  (res.show_seconds),
		.out_progress (res.progress_fraction),
		.out_pulse    (res.finished_pulse)
	);

endmodule

`default_nettype wire

// ===== rtl/cdt_checker.sv =====
// ---------------------------------------------------------------------------
// cdt_checker
// Port-level checks of the countdown timer, bound to the core.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cdt_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic [1:0]                        timer_state,
	input wire logic [cdt_pkg::MS_W-1:0]          remaining_ms,
	input wire logic [cdt_pkg::MIN_W-1:0]         show_minutes,
	input wire logic [cdt_pkg::SEC_W-1:0]         show_seconds,
	input wire logic [cdt_pkg::PROG_W-1:0]        progress_fraction,
	input wire logic                              finished_pulse
);

	// a stalled result holds
	`CDT_ASSERT_NXT(a_res_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(timer_state) && $stable(remaining_ms))

	// one command at a time: ready drops right after a transfer
	`CDT_ASSERT_NXT(a_one_cmd, clk, arst_n, in_valid && in_ready, !in_ready)

	// finish flag only with a finished, empty countdown
	`CDT_ASSERT_IMP(a_pulse_fin, clk, arst_n, out_valid && finished_pulse, timer_state == cdt_pkg::RS_FINISHED && remaining_ms == '0)

	// split and progress stay in range
	`CDT_ASSERT_IMP(a_ranges, clk, arst_n, out_valid, progress_fraction <= 17'd65536 && show_minutes < 6'd60 && show_seconds < 6'd60)

	// idle timer has no elapsed time
	`CDT_ASSERT_IMP(a_idle_zero, clk, arst_n, out_valid && timer_state == cdt_pkg::RS_IDLE, progress_fraction == '0 && !finished_pulse)

endmodule

bind countdown_timer_pause_extend_core cdt_checker u_cdt_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (cmd.valid),
	.in_ready          (cmd.ready),
	.out_valid         (res.valid),
	.out_ready         (res.ready),
	.timer_state       (res.timer_state),
	.remaining_ms      (res.remaining_ms),
	.show_minutes      (res.show_minutes),
	.show_seconds      (res.show_seconds),
	.progress_fraction (res.progress_fraction),
	.finished_pulse    (res.finished_pulse)
);

`default_nettype wire
